// ===== src/hsl_pkg.sv =====
`default_nettype none

package hsl_pkg;

    localparam int CH_W       = 8;
    localparam int OUT_W      = 16;
    localparam int DIV_Q_W    = 17;
    localparam int DIV_N_W    = CH_W + DIV_Q_W;
    localparam int DIV_STAGES = DIV_Q_W;
    localparam int SUM_W      = CH_W + 1;
    localparam int T_W        = 26;

    // hue scale: one sixth of a turn in degrees*128, and the full turn
    localparam int HUE_SIXTH  = 7680;
    localparam int HUE_THIRD  = 15360;
    localparam int HUE_2THIRD = 30720;
    localparam int HUE_TURN   = 46080;
    localparam int HALF_SUM   = 255;
    localparam int FULL_SUM   = 510;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } pixel_in_t;

    typedef struct packed {
        logic [OUT_W-1:0] hue;
        logic [OUT_W-1:0] saturation;
        logic [OUT_W-1:0] lightness;
        logic             is_grey;
    } hsl_out_t;

    typedef enum logic [1:0] {
        MAX_RED,
        MAX_GREEN,
        MAX_BLUE
    } max_sel_t;

    // what the front end hands to the two dividers and the sideband line
    typedef struct packed {
        logic               vld;
        logic               grey;
        logic [OUT_W-1:0]   light;
        logic [DIV_N_W-1:0] hue_num;
        logic [CH_W-1:0]    hue_den;
        logic [DIV_N_W-1:0] sat_num;
        logic [CH_W-1:0]    sat_den;
    } front_t;

endpackage

`default_nettype wire

// ===== src/rgb_to_hsl_pixel_unit.sv =====
`default_nettype none

// throughput: one pixel per cycle, busy is never raised
// the two 17-stage bit-per-stage dividers set the depth (2 front stages,
// 17 divider stages, 1 rounding/output stage)
// reset clears all valid bits; the receiver cannot stall, done pulses once per pixel
module rgb_to_hsl_pixel_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire hsl_pkg::pixel_in_t pixel,
    output logic                    busy,
    output logic                    done,
    output hsl_pkg::hsl_out_t       result
);
    import hsl_pkg::*;

    localparam int LATENCY = DIV_STAGES + 3;

    front_t               front;
    logic [DIV_Q_W-1:0]   hue_q, sat_q;

    hsl_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .pixel (pixel),
        .front (front)
    );

    hsl_div u_hue_div (
        .clk      (clk),
        .dividend (front.hue_num),
        .divisor  (front.hue_den),
        .quotient (hue_q)
    );

    hsl_div u_sat_div (
        .clk      (clk),
        .dividend (front.sat_num),
        .divisor  (front.sat_den),
        .quotient (sat_q)
    );

    // sideband line alongside the dividers
    logic             sb_vld_reg   [DIV_STAGES];
    logic             sb_grey_reg  [DIV_STAGES];
    logic [OUT_W-1:0] sb_light_reg [DIV_STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_STAGES; i++)
                sb_vld_reg[i] <= 1'b0;
        end
        else
        begin
            sb_vld_reg[0] <= front.vld;
            for (int i = 1; i < DIV_STAGES; i++)
                sb_vld_reg[i] <= sb_vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        sb_grey_reg[0]  <= front.grey;
        sb_light_reg[0] <= front.light;
        for (int i = 1; i < DIV_STAGES; i++)
        begin
            sb_grey_reg[i]  <= sb_grey_reg[i-1];
            sb_light_reg[i] <= sb_light_reg[i-1];
        end
    end

    // round to nearest: quotients carry one extra fraction bit
    logic               done_reg, done_next;
    hsl_out_t           result_reg, result_next;
    logic [DIV_Q_W-1:0] hue_p1, sat_p1;
    logic               grey_last;

    always_comb
    begin
        grey_last = sb_grey_reg[DIV_STAGES-1];
        hue_p1    = hue_q + DIV_Q_W'(1);
        sat_p1    = sat_q + DIV_Q_W'(1);

        done_next              = sb_vld_reg[DIV_STAGES-1];
        result_next.hue        = grey_last ? '0 : hue_p1[DIV_Q_W-1:1];
        result_next.saturation = grey_last ? '0 : sat_p1[DIV_Q_W-1:1];
        result_next.lightness  = sb_light_reg[DIV_STAGES-1];
        result_next.is_grey    = grey_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;

    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("done without a matching start");

    a_grey_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.is_grey |-> result.hue == '0 && result.saturation == '0)
        else $error("grey pixel with nonzero hue or saturation");

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.hue <= OUT_W'(HUE_TURN))
        else $error("hue beyond one turn");

endmodule

`default_nettype wire

// ===== src/hsl_front.sv =====
`default_nettype none

module hsl_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire hsl_pkg::pixel_in_t pixel,
    output hsl_pkg::front_t        front
);
    import hsl_pkg::*;

    // stage a: extremes and the max channel
    logic                   a_vld_reg, a_vld_next;
    logic [SUM_W-1:0]       a_sum_reg, a_sum_next;
    logic [CH_W-1:0]        a_d_reg, a_d_next;
    logic signed [SUM_W-1:0] a_n_reg, a_n_next;
    max_sel_t               a_sel_reg, a_sel_next;

    logic [CH_W-1:0] mx, mn;

    always_comb
    begin
        mx = pixel.red;
        mn = pixel.red;
        if (pixel.green > mx) mx = pixel.green;
        if (pixel.blue > mx)  mx = pixel.blue;
        if (pixel.green < mn) mn = pixel.green;
        if (pixel.blue < mn)  mn = pixel.blue;

        a_vld_next = start;
        a_sum_next = SUM_W'(mx) + SUM_W'(mn);
        a_d_next   = mx - mn;
        if (pixel.red == mx)
        begin
            a_sel_next = MAX_RED;
            a_n_next   = signed'({1'b0, pixel.green}) - signed'({1'b0, pixel.blue});
        end
        else if (pixel.green == mx)
        begin
            a_sel_next = MAX_GREEN;
            a_n_next   = signed'({1'b0, pixel.blue}) - signed'({1'b0, pixel.red});
        end
        else
        begin
            a_sel_next = MAX_BLUE;
            a_n_next   = signed'({1'b0, pixel.red}) - signed'({1'b0, pixel.green});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= a_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_sum_reg <= a_sum_next;
        a_d_reg   <= a_d_next;
        a_n_reg   <= a_n_next;
        a_sel_reg <= a_sel_next;
    end

    // stage b: divider operands and lightness
    front_t front_reg, front_next;

    logic signed [T_W-1:0] n_ext, d_ext, t_raw, t_wrap, t_off;
    logic [SUM_W+CH_W-1:0] light_full;

    always_comb
    begin
        n_ext = T_W'(a_n_reg);
        d_ext = signed'(T_W'(a_d_reg));
        case (a_sel_reg)
            MAX_RED:   t_off = '0;
            MAX_GREEN: t_off = T_W'(HUE_THIRD) * d_ext;
            MAX_BLUE:  t_off = T_W'(HUE_2THIRD) * d_ext;
            default:   t_off = '0;
        endcase
        t_raw = T_W'(HUE_SIXTH) * n_ext + t_off;
        // negative angle wraps by one turn
        if (t_raw < 0)
            t_wrap = t_raw + T_W'(HUE_TURN) * d_ext;
        else
            t_wrap = t_raw;

        light_full = (SUM_W+CH_W)'(a_sum_reg) * (SUM_W+CH_W)'(257) + (SUM_W+CH_W)'(1);

        front_next.vld     = a_vld_reg;
        front_next.grey    = (a_d_reg == '0);
        front_next.light   = light_full[OUT_W:1];
        front_next.hue_num = {t_wrap[DIV_N_W-2:0], 1'b0};
        front_next.hue_den = a_d_reg;
        // 2*d*65535 = (d << 17) - (d << 1)
        front_next.sat_num = {a_d_reg, {DIV_Q_W{1'b0}}} - DIV_N_W'({a_d_reg, 1'b0});
        if (a_sum_reg < SUM_W'(HALF_SUM))
            front_next.sat_den = a_sum_reg[CH_W-1:0];
        else
            front_next.sat_den = CH_W'(SUM_W'(FULL_SUM) - a_sum_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
        end
        else
        begin
            front_reg <= front_next;
        end
    end

    assign front = front_reg;

endmodule

`default_nettype wire

// ===== src/hsl_div.sv =====
`default_nettype none

module hsl_div (
    input  wire logic                          clk,
    input  wire logic [hsl_pkg::DIV_N_W-1:0]   dividend,
    input  wire logic [hsl_pkg::CH_W-1:0]      divisor,
    output logic      [hsl_pkg::DIV_Q_W-1:0]   quotient
);
    import hsl_pkg::*;

    // restoring division, one quotient bit per stage; the accumulator holds
    // the partial remainder on top and shifts quotient bits in at the bottom
    logic [DIV_N_W-1:0] acc_reg [DIV_STAGES];
    logic [CH_W-1:0]    dvs_reg [DIV_STAGES];

    genvar k;
    generate
        for (k = 0; k < DIV_STAGES; k++)
        begin : g_step
            logic [DIV_N_W-1:0] acc_in, acc_next;
            logic [CH_W-1:0]    dvs_in;
            logic [CH_W:0]      trial, diff;
            logic               take;

            if (k == 0)
            begin : g_first
                assign acc_in = dividend;
                assign dvs_in = divisor;
            end
            else
            begin : g_rest
                assign acc_in = acc_reg[k-1];
                assign dvs_in = dvs_reg[k-1];
            end

            always_comb
            begin
                trial    = acc_in[DIV_N_W-1:DIV_Q_W-1];
                diff     = trial - {1'b0, dvs_in};
                take     = (trial >= {1'b0, dvs_in});
                acc_next = {take ? diff[CH_W-1:0] : trial[CH_W-1:0],
                            acc_in[DIV_Q_W-2:0], take};
            end

            always_ff @(posedge clk)
            begin
                acc_reg[k] <= acc_next;
                dvs_reg[k] <= dvs_in;
            end
        end
    endgenerate

    assign quotient = acc_reg[DIV_STAGES-1][DIV_Q_W-1:0];

endmodule

`default_nettype wire

// ===== tb/sv/hsl_checker.sv =====
`default_nettype none

module hsl_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic               busy,
    input  wire hsl_pkg::pixel_in_t pixel,
    input  wire logic               done,
    input  wire hsl_pkg::hsl_out_t  result,
    output int                      fail_count,
    output int                      pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import hsl_pkg::*;

    hsl_out_t expected_hsl[$];

    initial
    begin
        fail_count    = 0;
        pending_count = 0;
    end

    function automatic hsl_out_t convert_pixel(input pixel_in_t p);
        hsl_out_t  o;
        max_sel_t  sel;
        longint    r;
        longint    g;
        longint    b;
        longint    mx;
        longint    mn;
        longint    dlt;
        longint    sum;
        longint    den;
        longint    t;
        r   = longint'(p.red);
        g   = longint'(p.green);
        b   = longint'(p.blue);
        mx  = r;
        mn  = r;
        sel = MAX_RED;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        dlt = mx - mn;
        sum = mx + mn;
        o.lightness  = OUT_W'((sum * 257 + 1) / 2);
        o.is_grey    = (dlt == 0);
        o.hue        = '0;
        o.saturation = '0;
        if (dlt != 0)
        begin
            den          = (sum < HALF_SUM) ? sum : (FULL_SUM - sum);
            o.saturation = OUT_W'((2 * dlt * 65535 + den) / (2 * den));
            // red wins ties, then green
            if (r == mx)
                sel = MAX_RED;
            else if (g == mx)
                sel = MAX_GREEN;
            else
                sel = MAX_BLUE;
            case (sel)
                MAX_RED:   t = HUE_SIXTH * (g - b);
                MAX_GREEN: t = HUE_SIXTH * (b - r) + HUE_THIRD * dlt;
                default:   t = HUE_SIXTH * (r - g) + HUE_2THIRD * dlt;
            endcase
            if (t < 0)
                t += HUE_TURN * dlt;
            o.hue = OUT_W'((2 * t + dlt) / (2 * dlt));
        end
        return o;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: hsl mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk)
    begin
        hsl_out_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_hsl.size() == 0)
                    report_mismatch("unexpected result transfer", 1, 0);
                else
                begin
                    want = expected_hsl.pop_front();
                    if (result.hue !== want.hue)
                        report_mismatch("hue", result.hue, want.hue);
                    if (result.saturation !== want.saturation)
                        report_mismatch("saturation", result.saturation, want.saturation);
                    if (result.lightness !== want.lightness)
                        report_mismatch("lightness", result.lightness, want.lightness);
                    if (result.is_grey !== want.is_grey)
                        report_mismatch("is_grey", result.is_grey, want.is_grey);
                end
            end
            if (start && !busy)
                expected_hsl.push_back(convert_pixel(pixel));
            pending_count = expected_hsl.size();
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/tb_rgb_to_hsl_pixel_unit.sv =====
`default_nettype none

module tb_rgb_to_hsl_pixel_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import hsl_pkg::*;

    localparam int RANDOM_PIXELS = 400;
    localparam int DRAIN_CYCLES  = 25;

    logic      clk;
    logic      rst_n;
    logic      start;
    pixel_in_t pixel;
    logic      busy;
    logic      done;
    hsl_out_t  result;
    int        fail_count;
    int        pending_count;

    rgb_to_hsl_pixel_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .pixel  (pixel),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    hsl_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .pixel         (pixel),
        .done          (done),
        .result        (result),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
        clk = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #500us;
        $display("tb_rgb_to_hsl_pixel_unit failed");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    function automatic pixel_in_t make_pixel();
        pixel_in_t p;
        logic [7:0] base;
        logic [7:0] other;
        base  = 8'($urandom);
        other = 8'($urandom);
        p     = pixel_in_t'($urandom);
        case ($urandom_range(0, 9))
            0: p = '{base, base, base};
            // two channels tie for the maximum
            1: p = '{8'hff, 8'hff, other};
            2: begin
                   if (other > base)
                       {base, other} = {other, base};
                   case ($urandom_range(0, 2))
                       0:       p = '{base, base, other};
                       1:       p = '{other, base, base};
                       default: p = '{base, other, base};
                   endcase
               end
            // near-grey: smallest deltas
            3: begin
                   p.red   = base;
                   p.green = (base == 8'hff) ? base - 8'($urandom_range(0, 1))
                                             : base + 8'($urandom_range(0, 1));
                   p.blue  = (base == 8'h00) ? base : base - 8'($urandom_range(0, 1));
               end
            // max+min around the lightness one-half boundary
            4: begin
                   base  = 8'($urandom_range(128, 255));
                   other = 8'(255 - int'(base) + $urandom_range(0, 2) - 1);
                   p     = '{base, other, 8'($urandom_range(int'(other), int'(base)))};
                   if ($urandom_range(0, 1))
                       p = '{p.blue, p.red, p.green};
               end
            default: ;
        endcase
        return p;
    endfunction

    task automatic send_pixel(input pixel_in_t p, input int gap);
        start <= 1'b1;
        pixel <= p;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            pixel <= pixel_in_t'($urandom);
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_rgb(input int r, input int g, input int b);
        send_pixel('{8'(r), 8'(g), 8'(b)}, pick_gap());
    endtask

    initial
    begin
        int gap;
        start <= 1'b0;
        pixel <= '0;
        rst_n <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_rgb(0, 0, 0);
        send_rgb(255, 255, 255);
        send_rgb(128, 128, 128);
        send_rgb(255, 0, 0);
        send_rgb(0, 255, 0);
        send_rgb(0, 0, 255);
        send_rgb(255, 255, 0);
        send_rgb(0, 255, 255);
        send_rgb(255, 0, 255);
        // red max with green below blue wraps the hue
        send_rgb(255, 0, 1);
        send_rgb(200, 10, 190);
        send_rgb(1, 0, 0);
        send_rgb(255, 254, 255);
        send_rgb(254, 0, 0);
        send_rgb(255, 0, 0);
        send_rgb(128, 127, 127);
        send_rgb(127, 128, 127);
        send_rgb(170, 85, 170);
        send_rgb(10, 20, 30);
        send_rgb(30, 255, 200);
        send_rgb(0, 1, 255);
        send_rgb(85, 170, 255);

        for (int i = 0; i < RANDOM_PIXELS; i++)
        begin
            // every third block of 40 runs back to back
            gap = ((i / 40) % 3 == 1) ? 0 : pick_gap();
            send_pixel(make_pixel(), gap);
        end
        start <= 1'b0;

        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        // every transfer in must have come back out
        if (fail_count == 0 && pending_count == 0)
            $display("tb_rgb_to_hsl_pixel_unit passed");
        else
            $display("tb_rgb_to_hsl_pixel_unit failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
src/hsl_pkg.sv
src/hsl_front.sv
src/hsl_div.sv
src/rgb_to_hsl_pixel_unit.sv
tb/sv/hsl_checker.sv
tb/sv/tb_rgb_to_hsl_pixel_unit.sv
